FILE: rtl/sci_pkg.sv
`timescale 1ns / 1ps
package sci_pkg;
	localparam int COORD_BITS = 24;
	localparam int CW = COORD_BITS;
	localparam int DW = CW + 1;
	localparam int RW = CW - 1;
	localparam int R2W = 2 * RW;
	localparam int SW = 2 * CW + 3;
	localparam int AW = 2 * CW + 2;
	localparam int MW = 2 * CW + 4;
	localparam int MH = MW / 2;
	localparam int PRW = 2 * MW;
	localparam int QS = 4 * CW;
	localparam int RB = 2 * CW;
	localparam int RMW = RB + 4;
	localparam int QB = CW + 3;
	localparam int NMW = AW + QB;
	localparam int PW = QB + 2;
	localparam int MUL_LAT = 4;
	localparam int SQRT_LAT = RB;
	localparam int DIV_LAT = QB + 2;
	localparam int L3_LEN = MUL_LAT + DIV_LAT;
	localparam int IN_BITS = 7 * CW + RW;
	localparam int IN_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_W = ((3 * CW + 7) / 8) * 8;

	// per-item data that rides beside the arithmetic units
	typedef struct packed {
		logic vld;
		logic dz;
		logic qneg;
		logic bneg;
		logic szero;
		logic signed [CW-1:0] sx;
		logic signed [CW-1:0] sy;
		logic signed [CW-1:0] ex;
		logic signed [CW-1:0] ey;
		logic signed [CW-1:0] sz;
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
		logic signed [SW-1:0] b;
		logic [AW-1:0] a;
	} side_t;
endpackage

FILE: rtl/sci_mul.sv
`timescale 1ns / 1ps
module sci_mul (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [sci_pkg::MW-1:0]  op_a,
	input  logic signed [sci_pkg::MW-1:0]  op_b,
	output logic signed [sci_pkg::PRW-1:0] prod
);
	import sci_pkg::*;

	localparam int PPW = 2 * MH;

	logic          sgn_s1, sgn_s2, sgn_s3;
	logic [MW-1:0] ma_s1, mb_s1;
	logic [PPW-1:0] pll_s2, plh_s2, phl_s2, phh_s2;
	logic [PRW-1:0] sum_s3;
	logic signed [PRW-1:0] prod_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s1 <= op_a[MW-1] ^ op_b[MW-1];
			ma_s1  <= op_a[MW-1] ? MW'(-op_a) : MW'(op_a);
			mb_s1  <= op_b[MW-1] ? MW'(-op_b) : MW'(op_b);
			sgn_s2 <= sgn_s1;
			pll_s2 <= PPW'(ma_s1[MH-1:0]) * PPW'(mb_s1[MH-1:0]);
			plh_s2 <= PPW'(ma_s1[MH-1:0]) * PPW'(mb_s1[MW-1:MH]);
			phl_s2 <= PPW'(ma_s1[MW-1:MH]) * PPW'(mb_s1[MH-1:0]);
			phh_s2 <= PPW'(ma_s1[MW-1:MH]) * PPW'(mb_s1[MW-1:MH]);
			sgn_s3 <= sgn_s2;
			sum_s3 <= {phh_s2, pll_s2} + (PRW'(plh_s2) << MH) + (PRW'(phl_s2) << MH);
			prod_s4 <= sgn_s3 ? -signed'(sum_s3) : signed'(sum_s3);
		end
	end

	assign prod = prod_s4;
endmodule

FILE: rtl/sci_sqrt.sv
`timescale 1ns / 1ps
module sci_sqrt (
	input  logic                      clk,
	input  logic                      en,
	input  logic [sci_pkg::QS-1:0]    rad,
	output logic [sci_pkg::RB-1:0]    root
);
	import sci_pkg::*;

	logic [RMW-1:0] rem_s  [RB];
	logic [RB-1:0]  root_s [RB];
	logic [QS-1:0]  rad_s  [RB];

	for (genvar k = 0; k < RB; k++) begin : g_step
		logic [RMW-1:0] rem_p, sh, tr;
		logic [RB-1:0]  root_p;
		logic [QS-1:0]  rad_p;
		logic           ge;
		if (k == 0) begin : g_first
			assign rem_p  = '0;
			assign root_p = '0;
			assign rad_p  = rad;
		end else begin : g_next
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign rad_p  = rad_s[k-1];
		end
		// bring down the next two radicand bits, try root*4+1
		assign sh = {rem_p[RMW-3:0], rad_p[QS-1 -: 2]};
		assign tr = RMW'({root_p, 2'b01});
		assign ge = sh >= tr;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? sh - tr : sh;
				root_s[k] <= {root_p[RB-2:0], ge};
				rad_s[k]  <= rad_p << 2;
			end
		end
	end

	assign root = root_s[RB-1];
endmodule

FILE: rtl/sci_div.sv
`timescale 1ns / 1ps
module sci_div (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [sci_pkg::PRW-1:0] num,
	input  logic [sci_pkg::AW-1:0]         den,
	output logic signed [sci_pkg::QB:0]    quo
);
	import sci_pkg::*;

	logic [PRW-1:0] absn;
	logic           sgn_s1;
	logic [AW-1:0]  rem_s1, den_s1;
	logic [QB-1:0]  lo_s1;

	logic [AW-1:0] rem_s [QB];
	logic [AW-1:0] den_s [QB];
	logic [QB-1:0] lo_s  [QB];
	logic [QB-1:0] qt_s  [QB];
	logic          sgn_s [QB];
	logic signed [QB:0] quo_sn;

	assign absn = num[PRW-1] ? PRW'(-num) : PRW'(num);

	// quotient magnitude stays below 2**QB, so the top part starts below den
	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s1 <= num[PRW-1];
			rem_s1 <= absn[NMW-1:QB];
			lo_s1  <= absn[QB-1:0];
			den_s1 <= den;
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [AW-1:0] rem_p, den_p;
		logic [QB-1:0] lo_p, qt_p;
		logic          sgn_p, ge;
		logic [AW:0]   shl, diff;
		if (k == 0) begin : g_first
			assign rem_p = rem_s1;
			assign den_p = den_s1;
			assign lo_p  = lo_s1;
			assign qt_p  = '0;
			assign sgn_p = sgn_s1;
		end else begin : g_next
			assign rem_p = rem_s[k-1];
			assign den_p = den_s[k-1];
			assign lo_p  = lo_s[k-1];
			assign qt_p  = qt_s[k-1];
			assign sgn_p = sgn_s[k-1];
		end
		assign shl  = {rem_p, lo_p[QB-1]};
		assign ge   = shl >= {1'b0, den_p};
		assign diff = shl - {1'b0, den_p};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[AW-1:0] : shl[AW-1:0];
				den_s[k] <= den_p;
				lo_s[k]  <= lo_p << 1;
				qt_s[k]  <= {qt_p[QB-2:0], ge};
				sgn_s[k] <= sgn_p;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_sn <= sgn_s[QB-1] ? -signed'({1'b0, qt_s[QB-1]}) : signed'({1'b0, qt_s[QB-1]});
		end
	end

	assign quo = quo_sn;
endmodule

FILE: rtl/segment_circle_intersection.sv
`timescale 1ns / 1ps
// segment / circle crossing test, one query per item, no state between items
// s_* channel: one query per item; s_tdata holds start_x, start_y, start_z, end_x,
//   end_y, center_x, center_y, radius from the lowest bit up, top bit zero
// m_* channel: one result per query; m_tuser is hit, m_tdata holds point_x,
//   point_y, point_z; all point fields are zero when there is no hit
// pipeline depth is set by the chain of product stages, the 48-stage square root
//   and the 29-stage dividers
// throughput: one item per cycle while the receiver does not stall, every stage is a register with a valid bit
// reset clears every valid bit, so the pipeline comes up empty and m_tvalid low
// when the receiver stalls with a result waiting, the whole pipeline freezes and
//   s_tready drops; nothing is dropped or repeated, bubbles are kept in place
module segment_circle_intersection (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// start_x, start_y, start_z, end_x, end_y, center_x, center_y, radius, pad
	input  logic [sci_pkg::IN_W-1:0]     s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// point_x, point_y, point_z
	output logic [sci_pkg::OUT_W-1:0]    m_tdata,
	// hit
	output logic                         m_tuser
);
	import sci_pkg::*;

	logic en;
	logic signed [CW-1:0] in_sx, in_sy, in_sz, in_ex, in_ey, in_cx, in_cy;
	logic [RW-1:0] in_r;

	side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;
	side_t side1_d, side3_d, side4_d, side5_d;
	side_t l1 [MUL_LAT];
	side_t l2 [SQRT_LAT];
	side_t l3 [L3_LEN];

	logic signed [DW-1:0] fx_s1, fy_s1;
	logic [RW-1:0] r_s1;
	logic signed [2*DW-1:0] dxx_s2, dyy_s2, dxfx_s2, dyfy_s2, dxfy_s2, dyfx_s2;
	logic [R2W-1:0] r2_s2, r2_s3;
	logic signed [SW-1:0] cross_s3;
	logic signed [PRW-1:0] ar, cc, qdiff, q_s4;
	logic [RB-1:0] root;
	logic signed [MW-1:0] nb, n1_s5, n2_s5;
	logic signed [PRW-1:0] m1x, m1y, m2x, m2y;
	logic signed [QB:0] q1x, q1y, q2x, q2y;
	logic signed [PW-1:0] p1x_s6, p1y_s6, p2x_s6, p2y_s6;
	logic signed [PW-1:0] sxw, syw, exw, eyw;
	logic in1, in2, ein, first, hit_d;
	logic signed [PW-1:0] selx, sely;

	logic out_vld_q, hit_q;
	logic signed [CW-1:0] px_q, py_q, pz_q;

	function automatic logic between(logic signed [PW-1:0] p, logic signed [PW-1:0] lo,
	                                 logic signed [PW-1:0] hi);
		return (p >= lo && p <= hi) || (p <= lo && p >= hi);
	endfunction

	assign en = !out_vld_q || m_tready;
	assign s_tready = en;

	assign in_sx = s_tdata[0*CW +: CW];
	assign in_sy = s_tdata[1*CW +: CW];
	assign in_sz = s_tdata[2*CW +: CW];
	assign in_ex = s_tdata[3*CW +: CW];
	assign in_ey = s_tdata[4*CW +: CW];
	assign in_cx = s_tdata[5*CW +: CW];
	assign in_cy = s_tdata[6*CW +: CW];
	assign in_r  = s_tdata[7*CW +: RW];

	always_comb begin
		side1_d       = '0;
		side1_d.vld   = s_tvalid;
		side1_d.dz    = (in_ex == in_sx) && (in_ey == in_sy);
		side1_d.sx    = in_sx;
		side1_d.sy    = in_sy;
		side1_d.ex    = in_ex;
		side1_d.ey    = in_ey;
		side1_d.sz    = in_sz;
		side1_d.dx    = DW'(in_ex) - DW'(in_sx);
		side1_d.dy    = DW'(in_ey) - DW'(in_sy);
	end

	always_comb begin
		side3_d   = side_s2;
		side3_d.a = AW'(dxx_s2 + dyy_s2);
		side3_d.b = SW'(dxfx_s2) + SW'(dyfy_s2);
	end

	// q = a*r^2 - (d x f)^2, the same quarter discriminant as B^2 - a*c
	assign qdiff = ar - cc;
	always_comb begin
		side4_d      = l1[MUL_LAT-1];
		side4_d.qneg = qdiff[PRW-1];
	end

	assign nb = -MW'(l2[SQRT_LAT-1].b);
	always_comb begin
		side5_d       = l2[SQRT_LAT-1];
		side5_d.szero = (root == '0);
		side5_d.bneg  = l2[SQRT_LAT-1].b[SW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1.vld <= 1'b0;
			side_s2.vld <= 1'b0;
			side_s3.vld <= 1'b0;
			side_s4.vld <= 1'b0;
			side_s5.vld <= 1'b0;
			side_s6.vld <= 1'b0;
			for (int i = 0; i < MUL_LAT; i++) l1[i].vld <= 1'b0;
			for (int i = 0; i < SQRT_LAT; i++) l2[i].vld <= 1'b0;
			for (int i = 0; i < L3_LEN; i++) l3[i].vld <= 1'b0;
		end else if (en) begin
			side_s1 <= side1_d;
			side_s2 <= side_s1;
			side_s3 <= side3_d;
			side_s4 <= side4_d;
			side_s5 <= side5_d;
			side_s6 <= l3[L3_LEN-1];
			l1[0] <= side_s3;
			for (int i = 1; i < MUL_LAT; i++) l1[i] <= l1[i-1];
			l2[0] <= side_s4;
			for (int i = 1; i < SQRT_LAT; i++) l2[i] <= l2[i-1];
			l3[0] <= side_s5;
			for (int i = 1; i < L3_LEN; i++) l3[i] <= l3[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fx_s1    <= DW'(in_sx) - DW'(in_cx);
			fy_s1    <= DW'(in_sy) - DW'(in_cy);
			r_s1     <= in_r;
			dxx_s2   <= side_s1.dx * side_s1.dx;
			dyy_s2   <= side_s1.dy * side_s1.dy;
			dxfx_s2  <= side_s1.dx * fx_s1;
			dyfy_s2  <= side_s1.dy * fy_s1;
			dxfy_s2  <= side_s1.dx * fy_s1;
			dyfx_s2  <= side_s1.dy * fx_s1;
			r2_s2    <= R2W'(r_s1) * R2W'(r_s1);
			cross_s3 <= SW'(dxfy_s2) - SW'(dyfx_s2);
			r2_s3    <= r2_s2;
			q_s4     <= qdiff;
			n1_s5    <= nb + signed'(MW'(root));
			n2_s5    <= nb - signed'(MW'(root));
			p1x_s6   <= PW'(l3[L3_LEN-1].sx) + PW'(q1x);
			p1y_s6   <= PW'(l3[L3_LEN-1].sy) + PW'(q1y);
			p2x_s6   <= PW'(l3[L3_LEN-1].sx) + PW'(q2x);
			p2y_s6   <= PW'(l3[L3_LEN-1].sy) + PW'(q2y);
		end
	end

	sci_mul u_mul_ar (.clk, .en, .op_a(signed'(MW'(side_s3.a))), .op_b(signed'(MW'(r2_s3))),
		.prod(ar));
	sci_mul u_mul_cc (.clk, .en, .op_a(MW'(cross_s3)), .op_b(MW'(cross_s3)), .prod(cc));

	sci_sqrt u_sqrt (.clk, .en, .rad(q_s4[QS-1:0]), .root);

	sci_mul u_mul_1x (.clk, .en, .op_a(MW'(side_s5.dx)), .op_b(n1_s5), .prod(m1x));
	sci_mul u_mul_1y (.clk, .en, .op_a(MW'(side_s5.dy)), .op_b(n1_s5), .prod(m1y));
	sci_mul u_mul_2x (.clk, .en, .op_a(MW'(side_s5.dx)), .op_b(n2_s5), .prod(m2x));
	sci_mul u_mul_2y (.clk, .en, .op_a(MW'(side_s5.dy)), .op_b(n2_s5), .prod(m2y));

	sci_div u_div_1x (.clk, .en, .num(m1x), .den(l3[MUL_LAT-1].a), .quo(q1x));
	sci_div u_div_1y (.clk, .en, .num(m1y), .den(l3[MUL_LAT-1].a), .quo(q1y));
	sci_div u_div_2x (.clk, .en, .num(m2x), .den(l3[MUL_LAT-1].a), .quo(q2x));
	sci_div u_div_2y (.clk, .en, .num(m2y), .den(l3[MUL_LAT-1].a), .quo(q2y));

	assign sxw = PW'(side_s6.sx);
	assign syw = PW'(side_s6.sy);
	assign exw = PW'(side_s6.ex);
	assign eyw = PW'(side_s6.ey);

	always_comb begin
		in1   = between(p1x_s6, sxw, exw) && between(p1y_s6, syw, eyw);
		in2   = between(p2x_s6, sxw, exw) && between(p2y_s6, syw, eyw);
		ein   = between(exw, p1x_s6, p2x_s6) && between(eyw, p1y_s6, p2y_s6);
		first = !side_s6.bneg || side_s6.szero;
		hit_d = !side_s6.dz && !side_s6.qneg && ((in1 && in2) || ein);
		if (first) begin
			selx = in1 ? p1x_s6 : sxw;
			sely = in1 ? p1y_s6 : syw;
		end else begin
			selx = in2 ? p2x_s6 : sxw;
			sely = in2 ? p2y_s6 : syw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= side_s6.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q <= hit_d;
			px_q  <= hit_d ? selx[CW-1:0] : '0;
			py_q  <= hit_d ? sely[CW-1:0] : '0;
			pz_q  <= hit_d ? side_s6.sz : '0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = hit_q;
	assign m_tdata  = OUT_W'({pz_q, py_q, px_q});

	a_nohit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("no-hit result carries a nonzero point");

	a_last_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		en && side_s6.vld |=> m_tvalid)
		else $error("valid item lost at output register");

	a_degenerate_miss: assert property (@(posedge clk) disable iff (!arst_n)
		en && side_s6.vld && (side_s6.dz || side_s6.qneg) |=> !m_tuser)
		else $error("hit reported for zero-length segment or negative discriminant");

	a_disc_range: assert property (@(posedge clk) disable iff (!arst_n)
		side_s4.vld && !side_s4.qneg |-> q_s4[PRW-1:QS] == '0)
		else $error("discriminant exceeds square root input range");
endmodule

FILE: tb/segment_circle_intersection_test.sv
`timescale 1ns / 1ps
module segment_circle_intersection_test;
	import sci_pkg::*;

	typedef bit signed [191:0] wide_t;

	typedef struct {
		bit signed [23:0] sx, sy, sz, ex, ey, cx, cy;
		bit [22:0] rad;
	} query_t;

	typedef struct {
		bit hit;
		bit [23:0] px, py, pz;
	} crossing_t;

	function automatic bit between(wide_t p, wide_t lo, wide_t hi);
		return (p >= lo && p <= hi) || (p <= lo && p >= hi);
	endfunction

	// exact wide arithmetic: every product and quotient fits in 192 bits
	function automatic crossing_t solve_crossing(query_t k);
		wide_t dx, dy, fx, fy, r, a, b, c, q, s, t, n1, n2, sxw, syw, exw, eyw;
		wide_t p1x, p1y, p2x, p2y, qx, qy;
		bit in1, in2;
		crossing_t res;
		res = '{default: 0};
		sxw = wide_t'(k.sx);
		syw = wide_t'(k.sy);
		exw = wide_t'(k.ex);
		eyw = wide_t'(k.ey);
		dx = exw - sxw;
		dy = eyw - syw;
		if (dx == 0 && dy == 0)
			return res;
		fx = sxw - wide_t'(k.cx);
		fy = syw - wide_t'(k.cy);
		r = wide_t'({1'b0, k.rad});
		a = dx * dx + dy * dy;
		b = dx * fx + dy * fy;
		c = fx * fx + fy * fy - r * r;
		q = b * b - a * c;
		if (q < 0)
			return res;
		s = 0;
		for (int i = 95; i >= 0; i--) begin
			t = s | (wide_t'(1) << i);
			if ($unsigned(t * t) <= $unsigned(q))
				s = t;
		end
		n1 = -b + s;
		n2 = -b - s;
		p1x = sxw + (dx * n1) / a;
		p1y = syw + (dy * n1) / a;
		p2x = sxw + (dx * n2) / a;
		p2y = syw + (dy * n2) / a;
		in1 = between(p1x, sxw, exw) && between(p1y, syw, eyw);
		in2 = between(p2x, sxw, exw) && between(p2y, syw, eyw);
		if (!((in1 && in2) || (between(exw, p1x, p2x) && between(eyw, p1y, p2y))))
			return res;
		if (b >= 0 || s == 0) begin
			qx = in1 ? p1x : sxw;
			qy = in1 ? p1y : syw;
		end else begin
			qx = in2 ? p2x : sxw;
			qy = in2 ? p2y : syw;
		end
		res.hit = 1;
		res.px = qx[23:0];
		res.py = qy[23:0];
		res.pz = k.sz;
		return res;
	endfunction

	class crossing_board;
		crossing_t pending[$];
		int errors = 0;

		function void note_query(query_t k);
			pending = {pending, solve_crossing(k)};
		endfunction

		function void check_result(bit hit, logic [OUT_W-1:0] d);
			crossing_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result hit=%0b data=%h", hit, d);
				return;
			end
			e = pending.pop_front();
			if (hit !== e.hit || d[23:0] !== e.px || d[47:24] !== e.py ||
			    d[71:48] !== e.pz) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp hit=%0b x=%h y=%h z=%h got hit=%0b x=%h y=%h z=%h",
						e.hit, e.px, e.py, e.pz, hit, d[23:0], d[47:24], d[71:48]);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [OUT_W-1:0] m_tdata;
	logic m_tuser;

	crossing_board board = new();
	query_t cur_query;
	int cycles = 0;
	int stall_left = 0;

	segment_circle_intersection u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial forever #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("DONE: errors detected");
			$finish;
		end
		if (s_tvalid && s_tready)
			board.note_query(cur_query);
		if (m_tvalid && m_tready)
			board.check_result(m_tuser, m_tdata);
	end

	// receiver: mostly ready, short and occasional long stalls
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready = 0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready = 0;
		end else begin
			case ($urandom_range(0, 19))
				0, 1, 2: stall_left = $urandom_range(0, 3);
				3: stall_left = $urandom_range(10, 60);
				default: stall_left = 0;
			endcase
			m_tready = (stall_left == 0);
		end
	end

	function automatic int gap_len();
		case ($urandom_range(0, 19))
			0, 1, 2, 3: return $urandom_range(1, 3);
			4: return $urandom_range(10, 50);
			default: return 0;
		endcase
	endfunction

	// occasional degenerate segment: start equals end on both axes
	function automatic int sx_same();
		return 0;
	endfunction

	task automatic send_query(query_t k);
		int gap;
		gap = gap_len();
		repeat (gap) begin
			@(negedge clk);
			s_tvalid = 0;
		end
		@(negedge clk);
		cur_query = k;
		s_tdata = {1'b0, k.rad, k.cy, k.cx, k.ey, k.ex, k.sz, k.sy, k.sx};
		s_tvalid = 1;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_geom(int sx, int sy, int ex, int ey, int cx, int cy, int rad, int sz);
		query_t k;
		k.sx = 24'(sx); k.sy = 24'(sy); k.ex = 24'(ex); k.ey = 24'(ey);
		k.cx = 24'(cx); k.cy = 24'(cy); k.rad = 23'(rad); k.sz = 24'(sz);
		send_query(k);
	endtask

	// well-formed: circle placed near the segment so crossings happen often
	task automatic send_near_query();
		int scale, sx, sy, ex, ey, tx, ty, rad;
		scale = 1 << $urandom_range(3, 21);
		sx = $signed($urandom_range(0, 2 * scale)) - scale;
		sy = $signed($urandom_range(0, 2 * scale)) - scale;
		ex = sx + $signed($urandom_range(0, 2 * scale)) - scale;
		ey = sy + $signed($urandom_range(0, 2 * scale)) - scale;
		tx = sx + ((ex - sx) * $signed($urandom_range(0, 16)) - 4 * (ex - sx)) / 8;
		ty = sy + ((ey - sy) * $signed($urandom_range(0, 16)) - 4 * (ey - sy)) / 8;
		tx += $signed($urandom_range(0, scale)) - scale / 2;
		ty += $signed($urandom_range(0, scale)) - scale / 2;
		rad = $urandom_range(0, 2 * scale);
		send_geom(sx, sy, ex, ey, tx, ty, rad, $urandom);
	endtask

	task automatic send_noise_query();
		query_t k;
		k.sx = 24'($urandom); k.sy = 24'($urandom); k.sz = 24'($urandom);
		k.ex = 24'($urandom); k.ey = 24'($urandom); k.cx = 24'($urandom);
		k.cy = 24'($urandom); k.rad = 23'($urandom);
		send_query(k);
	endtask

	initial begin
		int lo, hi;
		lo = -8388608;
		hi = 8388607;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// zero-length segment
		send_geom(1000, -2000, 1000, -2000, 1000, -2000, 500, 77);
		send_geom(lo, lo, lo, lo, 0, 0, hi, hi);
		// circle far away, negative discriminant
		send_geom(0, 0, 256, 0, 100000, 100000, 10, 5);
		// crossing through, both crossings inside the segment
		send_geom(-5000, 0, 5000, 0, 0, 0, 1000, -1);
		send_geom(5000, 0, -5000, 0, 0, 0, 1000, lo);
		// tangent, zero square root
		send_geom(-5000, 1000, 5000, 1000, 0, 0, 1000, hi);
		// start inside the circle, end outside
		send_geom(0, 0, 4000, 3000, 0, 0, 2000, 3);
		// end inside the circle
		send_geom(-4000, -3000, 0, 0, 0, 0, 2000, 4);
		// segment fully inside the circle
		send_geom(-10, -10, 10, 10, 0, 0, 5000, 6);
		// short of the circle
		send_geom(-9000, 0, -6000, 0, 0, 0, 1000, 7);
		// extreme coordinates and radius
		send_geom(lo, lo, hi, hi, 0, 0, hi, lo);
		send_geom(hi, lo, lo, hi, lo, lo, hi, hi);
		send_geom(lo, 0, hi, 0, hi, hi, 0, 0);
		send_geom(hi, hi, lo, lo, hi, lo, hi, -1);
		send_geom(0, lo, 0, hi, 0, 0, 0, 1);
		send_geom(lo, hi, hi, lo, hi, hi, 1, 2);
		// zero radius on the path
		send_geom(-100, 0, 100, 0, 0, 0, 0, 9);
		send_geom(0, 0, 100, 0, 0, 0, 0, 10);

		for (int n = 0; n < 500; n++) begin
			if (n == 250) begin
				@(negedge clk);
				s_tvalid = 0;
				while (board.pending.size() != 0) @(posedge clk);
			end
			case ($urandom_range(0, 9))
				0, 1: send_noise_query();
				2: send_geom(sx_same(), 0, 0, 0, $urandom, $urandom, $urandom, $urandom);
				default: send_near_query();
			endcase
		end
		@(negedge clk);
		s_tvalid = 0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (board.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

FILE: sim.f
rtl/sci_pkg.sv
rtl/sci_mul.sv
rtl/sci_sqrt.sv
rtl/sci_div.sv
rtl/segment_circle_intersection.sv
tb/segment_circle_intersection_test.sv
